@@ sv/uart_register_access_framer_macros.svh @@
// assertion macros for the uart register access framer
// used by the top level only; expects clk and rst_n in scope
`ifndef UART_REGISTER_ACCESS_FRAMER_MACROS_SVH
`define UART_REGISTER_ACCESS_FRAMER_MACROS_SVH

// condition implies consequence in the same cycle
`define URAF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define URAF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/uraf_pkg.sv @@
// types and constants for the uart register access framer
// no dependencies
package uraf_pkg;

    localparam logic [7:0]  SYNC_BYTE  = 8'hFE;
    localparam logic [15:0] FAIL_VALUE = 16'hFFFF;
    localparam int          READ_FLAG_BIT = 7;

    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_READ_CK    = 2'd1;
    localparam logic [1:0] ST_WRITE_ECHO = 2'd2;

    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_RX_BYTE = 1'b1;

    // byte positions within a frame
    localparam logic [2:0] POS_SYNC  = 3'd0;
    localparam logic [2:0] POS_ADDR  = 3'd1;
    localparam logic [2:0] POS_HIGH  = 3'd2;
    localparam logic [2:0] POS_LOW   = 3'd3;
    localparam logic [2:0] POS_CKSUM = 3'd4;

    // read reply collection count
    localparam logic [1:0] RX_NONE = 2'd0;
    localparam logic [1:0] RX_HIGH = 2'd1;

    typedef enum logic [2:0] {
        PEND_NONE  = 3'b001,
        PEND_READ  = 3'b010,
        PEND_WRITE = 3'b100
    } pend_t;

    typedef struct packed {
        logic        action;
        logic        is_read;
        logic [6:0]  reg_address;
        logic [15:0] write_value;
        logic [7:0]  rx_byte;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last_byte;
        logic [15:0] read_value;
        logic [1:0]  status;
    } rsp_t;

    // work handed from front to back: a frame to send or a report
    typedef struct packed {
        logic        is_report;
        logic        is_read;
        logic [7:0]  addr_byte;
        logic [7:0]  high_byte;
        logic [7:0]  low_byte;
        logic [7:0]  checksum;
        logic [15:0] value;
        logic [1:0]  status;
    } job_t;

endpackage

@@ sv/uraf_chan_if.sv @@
// valid/ready channel carrying one payload struct
// payload type is given per instance
interface uraf_chan_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/uraf_front.sv @@
// front part: accepts commands and received bytes, tracks the pending reply
// depends on uraf_pkg and uraf_chan_if
module uraf_front
    import uraf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    uraf_chan_if.sink   cmd,
    input  logic        job_full,
    output logic        job_push,
    output job_t        job_data
);

    pend_t       pend_reg, pend_next;
    logic [1:0]  rx_count_reg, rx_count_next;
    logic [7:0]  high_reg, high_next;
    logic [7:0]  low_reg, low_next;
    logic [7:0]  cksum_reg, cksum_next;

    logic        accept;
    logic [7:0]  addr_byte;
    logic [7:0]  wr_cksum;
    logic [7:0]  rx_sum;

    assign cmd.ready = !job_full;
    assign accept    = cmd.valid && cmd.ready;
    assign addr_byte = {cmd.data.is_read, cmd.data.reg_address};
    assign wr_cksum  = addr_byte + cmd.data.write_value[15:8] + cmd.data.write_value[7:0];
    assign rx_sum    = high_reg + low_reg;

    always_comb
    begin
        pend_next     = pend_reg;
        rx_count_next = rx_count_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        cksum_next    = cksum_reg;
        job_push      = 1'b0;
        job_data.is_report = 1'b0;
        job_data.is_read   = cmd.data.is_read;
        job_data.addr_byte = addr_byte;
        job_data.high_byte = cmd.data.write_value[15:8];
        job_data.low_byte  = cmd.data.write_value[7:0];
        job_data.checksum  = cmd.data.is_read ? addr_byte : wr_cksum;
        job_data.value     = FAIL_VALUE;
        job_data.status    = ST_OK;
        if (accept)
        begin
            if (cmd.data.action == ACT_COMMAND)
            begin
                // a new command drops whatever reply was pending
                job_push      = 1'b1;
                rx_count_next = RX_NONE;
                high_next     = 8'h00;
                low_next      = 8'h00;
                cksum_next    = job_data.checksum;
                pend_next     = cmd.data.is_read ? PEND_READ : PEND_WRITE;
            end
            else
            begin
                case (pend_reg)
                    PEND_READ:
                    begin
                        if (rx_count_reg == RX_NONE)
                        begin
                            high_next     = cmd.data.rx_byte;
                            rx_count_next = RX_HIGH;
                        end
                        else if (rx_count_reg == RX_HIGH)
                        begin
                            low_next      = cmd.data.rx_byte;
                            rx_count_next = rx_count_reg + 2'd1;
                        end
                        else
                        begin
                            pend_next          = PEND_NONE;
                            rx_count_next      = RX_NONE;
                            job_push           = 1'b1;
                            job_data.is_report = 1'b1;
                            if (cmd.data.rx_byte == rx_sum)
                            begin
                                job_data.value  = {high_reg, low_reg};
                                job_data.status = ST_OK;
                            end
                            else
                            begin
                                job_data.value  = FAIL_VALUE;
                                job_data.status = ST_READ_CK;
                            end
                        end
                    end
                    PEND_WRITE:
                    begin
                        pend_next          = PEND_NONE;
                        rx_count_next      = RX_NONE;
                        job_push           = 1'b1;
                        job_data.is_report = 1'b1;
                        job_data.value     = FAIL_VALUE;
                        job_data.status    = (cmd.data.rx_byte == cksum_reg) ? ST_OK
                                                                             : ST_WRITE_ECHO;
                    end
                    default:
                    begin
                        // byte with nothing pending is dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= PEND_NONE;
            rx_count_reg <= RX_NONE;
            high_reg     <= 8'h00;
            low_reg      <= 8'h00;
            cksum_reg    <= 8'h00;
        end
        else
        begin
            pend_reg     <= pend_next;
            rx_count_reg <= rx_count_next;
            high_reg     <= high_next;
            low_reg      <= low_next;
            cksum_reg    <= cksum_next;
        end
    end

endmodule

@@ sv/uraf_fifo.sv @@
// short job queue between front and back
// depends on uraf_pkg
module uraf_fifo
    import uraf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic avail,
    output job_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            entries_q [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign avail   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && avail;
    assign head    = entries_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_q[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/uraf_back.sv @@
// back part: turns queued jobs into transmit bytes and reports
// depends on uraf_pkg and uraf_chan_if
module uraf_back
    import uraf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_avail,
    input  job_t        job_head,
    output logic        job_pop,
    uraf_chan_if.source rsp
);

    job_t        job_reg, job_next;
    logic        busy_reg, busy_next;
    logic [2:0]  pos_reg, pos_next;
    logic        out_valid_reg, out_valid_next;
    rsp_t        out_reg, out_next;

    logic        out_load;
    logic        emit;
    logic        is_last;
    rsp_t        item;

    assign out_load = !out_valid_reg || rsp.ready;
    assign emit     = busy_reg && out_load;
    assign is_last  = job_reg.is_report
                   || (job_reg.is_read  && (pos_reg == POS_HIGH))
                   || (!job_reg.is_read && (pos_reg == POS_CKSUM));
    assign job_pop  = job_avail && (!busy_reg || (emit && is_last));

    always_comb
    begin
        item.kind       = KIND_TX;
        item.last_byte  = 1'b0;
        item.read_value = 16'h0000;
        item.status     = ST_OK;
        case (pos_reg)
            POS_SYNC:  item.tx_byte = SYNC_BYTE;
            POS_ADDR:  item.tx_byte = job_reg.addr_byte;
            // read frames end with their checksum in the third slot
            POS_HIGH:  item.tx_byte = job_reg.is_read ? job_reg.checksum : job_reg.high_byte;
            POS_LOW:   item.tx_byte = job_reg.low_byte;
            default:   item.tx_byte = job_reg.checksum;
        endcase
        if (job_reg.is_report)
        begin
            item.kind       = KIND_REPORT;
            item.tx_byte    = 8'h00;
            item.read_value = job_reg.value;
            item.status     = job_reg.status;
        end
        else
        begin
            item.last_byte = is_last;
        end
    end

    always_comb
    begin
        job_next       = job_reg;
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_load)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                out_next = item;
            end
        end
        if (emit)
        begin
            pos_next = pos_reg + 3'd1;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (job_pop)
        begin
            job_next  = job_head;
            busy_next = 1'b1;
            pos_next  = POS_SYNC;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= POS_SYNC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/uart_register_access_framer.sv @@
// top level of the uart register access framer: front, job queue, back
// depends on uraf_pkg, uraf_chan_if, uraf_front, uraf_fifo, uraf_back
//
//   channel  dir  payload  carries
//   cmd      in   cmd_t    register commands and bytes received from the chip
//   rsp      out  rsp_t    bytes to transmit and completion reports
//
// a command is taken while the queue has room; its frame leaves one byte per cycle
// unless rsp stalls: 3 for a read and 5 for a write, set by the back byte counter.
// received bytes are taken like commands; the last one queues a one-item report.
// cmd stalls only when the job queue is full; rsp stalls hold the output register.
// reset clears the pending reply, the queue and the output valid.
`include "uart_register_access_framer_macros.svh"

module uart_register_access_framer
    import uraf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    uraf_chan_if.sink   cmd,
    uraf_chan_if.source rsp
);

    logic job_push;
    job_t job_push_data;
    logic job_full;
    logic job_pop;
    logic job_avail;
    job_t job_head;

    uraf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .job_full (job_full),
        .job_push (job_push),
        .job_data (job_push_data)
    );

    uraf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_push_data),
        .full      (job_full),
        .pop       (job_pop),
        .avail     (job_avail),
        .head      (job_head)
    );

    uraf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (job_avail),
        .job_head  (job_head),
        .job_pop   (job_pop),
        .rsp       (rsp)
    );

    `URAF_ASSERT_SAME(a_no_push_when_full, job_push, !job_full, "job pushed into full queue")
    `URAF_ASSERT_NEXT(a_push_lands, job_push, job_avail, "pushed job missing from queue")
    `URAF_ASSERT_SAME(a_report_clean, rsp.valid && (rsp.data.kind == KIND_REPORT), (rsp.data.tx_byte == 8'h00) && !rsp.data.last_byte, "report carries transmit fields")
    `URAF_ASSERT_SAME(a_tx_clean, rsp.valid && (rsp.data.kind == KIND_TX), (rsp.data.read_value == 16'h0000) && (rsp.data.status == ST_OK), "transmit byte carries report fields")

endmodule
